FILE: rtl/core/gpgm_pkg.sv
// Shared types, constants and coefficient tables for the glint/pupil gaze mapper.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package gpgm_pkg;

  localparam int COORD_BITS     = 11;
  localparam int COEF_FRAC_BITS = 36;
  localparam int NGLINT         = 4;
  localparam int NTERM_X        = 8;
  localparam int NTERM_Y        = 7;
  localparam int GAZE_W         = 20;
  localparam int GAZE_MAX       = 524287;
  localparam int GAZE_MIN       = -524288;
  // Pipeline depth from accepted transaction to result strobe
  localparam int LATENCY        = 8;

  // Exact accumulator width: coefficient, fourth-order monomial and headroom
  localparam int ACC_W = COEF_FRAC_BITS + 4 * COORD_BITS + 20;
  localparam int SUM_W = ACC_W + 2;
  // Shift to 1/16 pixel after the divide by four
  localparam int RND_SHIFT = COEF_FRAC_BITS - 2;
  localparam longint unsigned Micro = 64'd1000000;

  typedef logic        [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   delta_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef struct packed {
    coord_t glint_a_x;
    coord_t glint_a_y;
    coord_t glint_b_x;
    coord_t glint_b_y;
    coord_t glint_c_x;
    coord_t glint_c_y;
    coord_t glint_d_x;
    coord_t glint_d_y;
    coord_t pupil_x;
    coord_t pupil_y;
  } gaze_in_t;

  typedef struct packed {
    logic signed [GAZE_W-1:0] gaze_x;
    logic signed [GAZE_W-1:0] gaze_y;
    logic                     saturated;
  } gaze_out_t;

  typedef struct packed {
    acc_t [NTERM_X-1:0] a;
    acc_t [NTERM_Y-1:0] b;
  } coef_set_t;

  typedef struct packed {
    acc_t sx;
    acc_t sy;
  } lane_sum_t;

  // Coefficients in units of 1e-6; x terms: 1 dx dy dx2 dx3 dxdy dx2dy dx3dy
  localparam longint CX_MICRO [NGLINT][NTERM_X] = '{
    '{236574875, 12459167, -1110212, -52689, 403, -29463, 1294, -7},
    '{697615479, 10136406, -659631, -1990, 454, 41473, 447, -7},
    '{726269653, 8985279, -656963, -15915, 704, 33213, 384, -7},
    '{295393463, 13015799, -1058814, -88046, 639, -22954, 1079, -7}
  };
  // y terms: 1 dx dy dx2 dy2 dxdy dx2dy
  localparam longint CY_MICRO [NGLINT][NTERM_Y] = '{
    '{1171261108, -606877, -11946161, -6476, -19261, 2177, -119},
    '{1123675415, -1167611, -11971226, -6496, -20796, -13616, -249},
    '{1799309204, -852376, -15101971, -12155, 9181, -7970, -23},
    '{1885803833, 514598, -16293446, -20861, 17816, -12899, 146}
  };

  // Decimal coefficient to signed fixed point, ties away from zero
  function automatic acc_t coef_q(input longint micro);
    longint unsigned m;
    longint unsigned q;
    longint unsigned rem;
    longint unsigned frac;
    acc_t            mag;
    m    = (micro < 0) ? longint'(-micro) : micro;
    q    = m / Micro;
    rem  = m % Micro;
    frac = 0;
    for (int i = 0; i < COEF_FRAC_BITS; i++) begin
      rem  = rem << 1;
      frac = frac << 1;
      if (rem >= Micro) begin
        rem  = rem - Micro;
        frac = frac | 64'd1;
      end
    end
    if (rem * 2 >= Micro) frac = frac + 64'd1;
    mag = (acc_t'(q) <<< COEF_FRAC_BITS) + acc_t'(frac);
    return (micro < 0) ? -mag : mag;
  endfunction

  function automatic coef_set_t coef_set(input int g);
    coef_set_t c;
    for (int t = 0; t < NTERM_X; t++) c.a[t] = coef_q(CX_MICRO[g][t]);
    for (int t = 0; t < NTERM_Y; t++) c.b[t] = coef_q(CY_MICRO[g][t]);
    return c;
  endfunction

endpackage

FILE: rtl/core/gpgm_lane.sv
// One glint lane: offset from the pupil and both polynomials in Horner form.
// Depends on gpgm_pkg. Five register stages, a new transaction every cycle.
`timescale 1ns / 1ps

module gpgm_lane (
  input  logic                clk,
  input  gpgm_pkg::coord_t    glint_x,
  input  gpgm_pkg::coord_t    glint_y,
  input  gpgm_pkg::coord_t    pupil_x,
  input  gpgm_pkg::coord_t    pupil_y,
  input  gpgm_pkg::coef_set_t coef,
  output gpgm_pkg::lane_sum_t sum
);
  import gpgm_pkg::*;

  // gx = a0 + dx(a1 + dx(a3 + a4 dx)) + dy(a2 + dx(a5 + dx(a6 + a7 dx)))
  // gy = b0 + dx(b1 + b3 dx) + dy(b2 + b4 dy + dx(b5 + b6 dx))

  delta_t dx0, dy0, dx1, dy1, dx2, dy2, dx3;
  acc_t   h1, k1, m1, n1, e1;
  acc_t   h2, k2, m2, n2;
  acc_t   h3, k3, y3;

  function automatic acc_t mul_d(input acc_t a, input delta_t d);
    return acc_t'(a * d);
  endfunction

  // Stage 0: signed offsets
  always_ff @(posedge clk) begin
    dx0 <= delta_t'({1'b0, glint_x}) - delta_t'({1'b0, pupil_x});
    dy0 <= delta_t'({1'b0, glint_y}) - delta_t'({1'b0, pupil_y});
  end

  // Stage 1: innermost Horner steps
  always_ff @(posedge clk) begin
    h1  <= mul_d(coef.a[4], dx0) + coef.a[3];
    k1  <= mul_d(coef.a[7], dx0) + coef.a[6];
    m1  <= mul_d(coef.b[3], dx0) + coef.b[1];
    n1  <= mul_d(coef.b[6], dx0) + coef.b[5];
    e1  <= mul_d(coef.b[4], dy0) + coef.b[2];
    dx1 <= dx0;
    dy1 <= dy0;
  end

  // Stage 2
  always_ff @(posedge clk) begin
    h2  <= mul_d(h1, dx1) + coef.a[1];
    k2  <= mul_d(k1, dx1) + coef.a[5];
    m2  <= mul_d(m1, dx1);
    n2  <= mul_d(n1, dx1) + e1;
    dx2 <= dx1;
    dy2 <= dy1;
  end

  // Stage 3: y finishes here
  always_ff @(posedge clk) begin
    h3  <= mul_d(h2, dx2);
    k3  <= mul_d(k2, dx2) + coef.a[2];
    y3  <= mul_d(n2, dy2) + m2 + coef.b[0];
    dx3 <= dy2;
  end

  // Stage 4: x finishes (dx3 holds dy here)
  always_ff @(posedge clk) begin
    sum.sx <= mul_d(k3, dx3) + h3 + coef.a[0];
    sum.sy <= y3;
  end

endmodule

FILE: rtl/core/gpgm_merge.sv
// Merge of the four lane estimates: sum, round to 1/16 pixel, saturate.
// Depends on gpgm_pkg. Three register stages.
`timescale 1ns / 1ps

module gpgm_merge (
  input  logic                clk,
  input  gpgm_pkg::lane_sum_t lane [gpgm_pkg::NGLINT],
  output gpgm_pkg::gaze_out_t result
);
  import gpgm_pkg::*;

  localparam sum_t Half = sum_t'(1) <<< (RND_SHIFT - 1);
  localparam sum_t Hi   = sum_t'(GAZE_MAX);
  localparam sum_t Lo   = sum_t'(GAZE_MIN);

  sum_t px0, px1, py0, py1;
  sum_t vx, vy;

  // Pairwise sums
  always_ff @(posedge clk) begin
    px0 <= sum_t'(lane[0].sx) + sum_t'(lane[1].sx);
    px1 <= sum_t'(lane[2].sx) + sum_t'(lane[3].sx);
    py0 <= sum_t'(lane[0].sy) + sum_t'(lane[1].sy);
    py1 <= sum_t'(lane[2].sy) + sum_t'(lane[3].sy);
  end

  // Total, round half up, scale
  always_ff @(posedge clk) begin
    vx <= (px0 + px1 + Half) >>> RND_SHIFT;
    vy <= (py0 + py1 + Half) >>> RND_SHIFT;
  end

  // Clip to the output range
  always_ff @(posedge clk) begin
    result.gaze_x    <= (vx > Hi) ? Hi[GAZE_W-1:0] :
                        (vx < Lo) ? Lo[GAZE_W-1:0] : vx[GAZE_W-1:0];
    result.gaze_y    <= (vy > Hi) ? Hi[GAZE_W-1:0] :
                        (vy < Lo) ? Lo[GAZE_W-1:0] : vy[GAZE_W-1:0];
    result.saturated <= (vx > Hi) || (vx < Lo) || (vy > Hi) || (vy < Lo);
  end

endmodule

FILE: rtl/core/glint_pupil_gaze_mapper.sv
// done is the last bit of a valid shift register that runs beside the lane and merge stages.
// Throughput: one transaction per cycle; busy stays low, four glint lanes in parallel.
// Reset (rst, synchronous): clears the valid pipeline only; no results follow.
// The receiver cannot stall: each result is shown for one cycle with done.
// Top level; depends on gpgm_pkg, gpgm_lane and gpgm_merge.
`timescale 1ns / 1ps

module glint_pupil_gaze_mapper (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  gpgm_pkg::gaze_in_t  frame,
  output logic                done,
  output gpgm_pkg::gaze_out_t result
);
  import gpgm_pkg::*;

  coord_t    gl_x [NGLINT];
  coord_t    gl_y [NGLINT];
  lane_sum_t lane_sum [NGLINT];
  logic [LATENCY-1:0] vld;

  assign busy = 1'b0;

  assign gl_x[0] = frame.glint_a_x;
  assign gl_y[0] = frame.glint_a_y;
  assign gl_x[1] = frame.glint_b_x;
  assign gl_y[1] = frame.glint_b_y;
  assign gl_x[2] = frame.glint_c_x;
  assign gl_y[2] = frame.glint_c_y;
  assign gl_x[3] = frame.glint_d_x;
  assign gl_y[3] = frame.glint_d_y;

  // One lane per glint, each with its own coefficient set
  for (genvar g = 0; g < NGLINT; g++) begin : g_lane
    gpgm_lane u_lane (
      .clk     (clk),
      .glint_x (gl_x[g]),
      .glint_y (gl_y[g]),
      .pupil_x (frame.pupil_x),
      .pupil_y (frame.pupil_y),
      .coef    (coef_set(g)),
      .sum     (lane_sum[g])
    );
  end

  gpgm_merge u_merge (
    .clk    (clk),
    .lane   (lane_sum),
    .result (result)
  );

  // Valid tracking alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  assign done = vld[LATENCY-1];

endmodule

FILE: rtl/core/gpgm_checker.sv
// Port-level checks for the gaze mapper, bound to the top level.
// Depends on gpgm_pkg and glint_pupil_gaze_mapper.
`timescale 1ns / 1ps

module gpgm_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input gpgm_pkg::gaze_out_t result
);
  import gpgm_pkg::*;

  localparam logic signed [GAZE_W-1:0] Hi = GAZE_W'(GAZE_MAX);
  localparam logic signed [GAZE_W-1:0] Lo = GAZE_W'(GAZE_MIN);

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy asserted");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("missing result for accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without transaction");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    done && result.saturated |->
      (result.gaze_x == Hi || result.gaze_x == Lo ||
       result.gaze_y == Hi || result.gaze_y == Lo))
    else $error("saturated flag without clipped coordinate");

endmodule

bind glint_pupil_gaze_mapper gpgm_checker u_gpgm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
